### rtl/egcd_pkg.sv
package egcd_pkg;

	// Operand width used by the datapath (2 to 64)
	localparam int WIDTH = 32;

	// Fixed width of the operand and divisor ports
	localparam int PORT_W = 32;

	// Width wide enough to hold either a port value or a full operand
	localparam int EXT_W = (WIDTH > PORT_W) ? WIDTH : PORT_W;

	// Shift count for the common power of two (at most WIDTH-1)
	localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	// Sequencer states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} egcd_state_t;

	// Status from the shared subtract/compare unit
	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic a_odd;
		logic b_odd;
		logic borrow;
	} egcd_flags_t;

endpackage

### rtl/egcd_alu.sv
module egcd_alu (
	input  logic [egcd_pkg::WIDTH-1:0] a,
	input  logic [egcd_pkg::WIDTH-1:0] b,
	output logic [egcd_pkg::WIDTH-1:0] diff,
	output egcd_pkg::egcd_flags_t      flags
);

	logic [egcd_pkg::WIDTH:0] sub_w;

	// Subtract once; the borrow doubles as the a < b compare
	assign sub_w = {1'b0, a} - {1'b0, b};
	assign diff  = sub_w[egcd_pkg::WIDTH-1:0];

	// Gather status for the sequencer
	always_comb begin
		flags.a_zero = (a == '0);
		flags.b_zero = (b == '0);
		flags.a_odd  = a[0];
		flags.b_odd  = b[0];
		flags.borrow = sub_w[egcd_pkg::WIDTH];
	end

endmodule

### rtl/euclid_gcd_unit.sv
// Greatest common divisor by the binary (shift and subtract) method on one shared subtractor.
// The subtract/compare step runs once per cycle; busy stays high for the whole operation.
// Throughput: one operation at a time; a new start is taken in the cycle done pulses.
// done pulses for one cycle with the result; the receiver cannot stall it.
// Reset clears the sequencer and the done strobe; no other state needs clearing.
module euclid_gcd_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [egcd_pkg::PORT_W-1:0]   operand_a,
	input  logic [egcd_pkg::PORT_W-1:0]   operand_b,
	output logic                          busy,
	output logic                          done,
	output logic [egcd_pkg::PORT_W-1:0]   divisor,
	output logic                          shares_factor
);

	egcd_pkg::egcd_state_t state_q;
	egcd_pkg::egcd_state_t state_d;

	logic [egcd_pkg::WIDTH-1:0]  a_q;
	logic [egcd_pkg::WIDTH-1:0]  b_q;
	logic [egcd_pkg::KW-1:0]     k_q;
	logic [egcd_pkg::WIDTH-1:0]  a_d;
	logic [egcd_pkg::WIDTH-1:0]  b_d;
	logic [egcd_pkg::KW-1:0]     k_d;

	logic [egcd_pkg::WIDTH-1:0]  diff;
	egcd_pkg::egcd_flags_t       flags;

	logic [egcd_pkg::EXT_W-1:0]  a_ext;
	logic [egcd_pkg::EXT_W-1:0]  b_ext;
	logic [egcd_pkg::EXT_W-1:0]  g_ext;
	logic [egcd_pkg::WIDTH-1:0]  odd_part;
	logic [egcd_pkg::WIDTH-1:0]  g_full;
	logic                        accept;
	logic                        finish;

	logic [egcd_pkg::PORT_W-1:0] divisor_q;
	logic                        shares_q;
	logic                        done_q;

	// Take the operands down to the working width
	assign a_ext  = egcd_pkg::EXT_W'(operand_a);
	assign b_ext  = egcd_pkg::EXT_W'(operand_b);
	assign accept = start && !busy;

	egcd_alu u_alu (
		.a     (a_q),
		.b     (b_q),
		.diff  (diff),
		.flags (flags)
	);

	// Finish once either value has reached zero; the other holds the odd part
	assign finish   = (state_q == egcd_pkg::ST_RUN) && (flags.a_zero || flags.b_zero);
	assign odd_part = flags.a_zero ? b_q : a_q;
	assign g_full   = odd_part << k_q;
	assign g_ext    = egcd_pkg::EXT_W'(g_full);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			egcd_pkg::ST_IDLE: begin
				if (start) state_d = egcd_pkg::ST_RUN;
			end
			egcd_pkg::ST_RUN: begin
				if (finish) state_d = egcd_pkg::ST_IDLE;
			end
			default: state_d = egcd_pkg::ST_IDLE;
		endcase
	end

	// Datapath step: load the operands while idle; while running, strip twos, swap to keep a >= b, or subtract and halve
	always_comb begin
		a_d = a_q;
		b_d = b_q;
		k_d = k_q;
		case (state_q)
			egcd_pkg::ST_IDLE: begin
				a_d = a_ext[egcd_pkg::WIDTH-1:0];
				b_d = b_ext[egcd_pkg::WIDTH-1:0];
				k_d = '0;
			end
			egcd_pkg::ST_RUN: begin
				if (flags.a_zero || flags.b_zero) begin
					a_d = a_q;
				end else if (!flags.a_odd && !flags.b_odd) begin
					a_d = a_q >> 1;
					b_d = b_q >> 1;
					k_d = k_q + egcd_pkg::KW'(1);
				end else if (!flags.a_odd) begin
					a_d = a_q >> 1;
				end else if (!flags.b_odd) begin
					b_d = b_q >> 1;
				end else if (flags.borrow) begin
					a_d = b_q;
					b_d = a_q;
				end else begin
					a_d = diff >> 1;
				end
			end
			default: begin
				a_d = a_q;
			end
		endcase
	end

	// Sequencer state and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egcd_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	// Working values and result; no reset needed
	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
		k_q <= k_d;
		if (finish) begin
			divisor_q <= g_ext[egcd_pkg::PORT_W-1:0];
			shares_q  <= (g_full > egcd_pkg::WIDTH'(1));
		end
	end

	assign busy          = (state_q != egcd_pkg::ST_IDLE);
	assign done          = done_q;
	assign divisor       = divisor_q;
	assign shares_factor = shares_q;

`ifndef SYNTHESIS
	// Busy drops only together with a result transfer
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result transfer");

	// Every operation passes through the working state, so done never repeats back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An accepted start always enters the working state
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted start did not raise busy");

	// A subtract step strictly shrinks the larger value
	a_sub_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == egcd_pkg::ST_RUN && !flags.a_zero && !flags.b_zero &&
		 flags.a_odd && flags.b_odd && !flags.borrow) |=> (a_q < $past(a_q)))
		else $error("subtract step did not reduce the operand");
`endif

endmodule

### dv/gcd_checker.sv
module gcd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [egcd_pkg::PORT_W-1:0] operand_a,
	input  logic [egcd_pkg::PORT_W-1:0] operand_b,
	input  logic                        done,
	input  logic [egcd_pkg::PORT_W-1:0] divisor,
	input  logic                        shares_factor,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW = egcd_pkg::PORT_W;

	// One expected result, with the operands kept for the report
	typedef struct packed {
		logic [PW-1:0] op_a;
		logic [PW-1:0] op_b;
		logic [PW-1:0] divisor;
		logic          shares_factor;
	} gcd_result_t;

	gcd_result_t gcd_expected[$];
	int          err_total = 0;
	int          wait_total = 0;

	assign fail_count = err_total;
	assign pending    = wait_total;

	// Euclid on the operands masked to the datapath width
	function automatic gcd_result_t gcd_of(logic [PW-1:0] a, logic [PW-1:0] b);
		logic [63:0] mask;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] greater;
		logic [63:0] lesser;
		logic [63:0] rem;
		gcd_result_t r;
		mask = (egcd_pkg::WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << egcd_pkg::WIDTH) - 64'd1);
		x = 64'(a) & mask;
		y = 64'(b) & mask;
		greater = (x >= y) ? x : y;
		lesser  = (x >= y) ? y : x;
		while (lesser != 0) begin
			rem = greater % lesser;
			greater = lesser;
			lesser = rem;
		end
		r.op_a = a;
		r.op_b = b;
		r.divisor = greater[PW-1:0];
		r.shares_factor = (greater > 64'd1);
		return r;
	endfunction

	// Compare each result strobe first, then record a new transfer
	always @(posedge clk) begin
		gcd_result_t want;
		if (arst_n) begin
			if (done) begin
				if (gcd_expected.size() == 0) begin
					if (err_total < 10)
						$display("%0t: result with nothing pending: divisor %0d flag %0b",
							$time, divisor, shares_factor);
					err_total++;
				end else begin
					want = gcd_expected.pop_front();
					wait_total--;
					if (divisor !== want.divisor || shares_factor !== want.shares_factor) begin
						if (err_total < 10)
							$display("%0t: gcd(%0d, %0d) expected %0d/%0b, got %0d/%0b",
								$time, want.op_a, want.op_b, want.divisor,
								want.shares_factor, divisor, shares_factor);
						err_total++;
					end
				end
			end
			if (start && !busy) begin
				gcd_expected.push_back(gcd_of(operand_a, operand_b));
				wait_total++;
			end
		end
	end

endmodule

### dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW         = egcd_pkg::PORT_W;
	localparam int TAIL_CYC   = 4 * egcd_pkg::WIDTH + 12;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 330;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [PW-1:0] operand_a = '0;
	logic [PW-1:0] operand_b = '0;
	logic          busy;
	logic          done;
	logic [PW-1:0] divisor;
	logic          shares_factor;
	int            fail_count;
	int            pending;
	int            idle_pct = 14;
	int            quiet_cycles = 0;

	euclid_gcd_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.busy         (busy),
		.done         (done),
		.divisor      (divisor),
		.shares_factor(shares_factor)
	);

	gcd_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.done         (done),
		.divisor      (divisor),
		.shares_factor(shares_factor),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #10 clk = ~clk;

	// Stop the run when nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Present one operand pair and hold it until the transfer; returns at a falling edge
	task automatic send_pair(input logic [PW-1:0] a, input logic [PW-1:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Drop start and hold off until every pending result has arrived
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Random pair drawn from a mix of shapes that stress the iteration
	task automatic send_random;
		int unsigned   kind;
		int unsigned   n;
		logic [PW-1:0] a;
		logic [PW-1:0] b;
		logic [PW-1:0] g;
		logic [PW-1:0] t;
		logic [PW-1:0] fa;
		logic [PW-1:0] fb;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: begin
				a = $urandom;
				b = $urandom;
			end
			3, 4: begin
				g = $urandom_range(2, 65535);
				a = g * PW'($urandom_range(1, 65535));
				b = g * PW'($urandom_range(1, 65535));
			end
			5: begin
				a = ($urandom | 1) << $urandom_range(0, 31);
				b = ($urandom | 1) << $urandom_range(0, 31);
			end
			6: begin
				a = $urandom_range(0, 255);
				b = $urandom_range(0, 255);
			end
			7: begin
				a = $urandom;
				b = $urandom_range(0, 1) ? a : '0;
			end
			8: begin
				// neighboring Fibonacci numbers take the most remainder steps
				n = $urandom_range(1, 46);
				fa = 1;
				fb = 0;
				repeat (n) begin
					t = fa + fb;
					fb = fa;
					fa = t;
				end
				a = fa;
				b = fb;
			end
			default: begin
				b = $urandom_range(1, 65535);
				a = b * PW'($urandom_range(1, 65535));
			end
		endcase
		if ($urandom_range(0, 1))
			send_pair(a, b);
		else
			send_pair(b, a);
	endtask

	initial begin
		int phase;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corners: zeros, equal, extremes, coprime, worst-case chains
		send_pair(32'd0, 32'd0);
		send_pair(32'd0, 32'd1);
		send_pair(32'd1, 32'd0);
		send_pair(32'd0, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'd0);
		send_pair(32'd1, 32'd1);
		send_pair(32'd2, 32'd2);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'd1);
		send_pair(32'd1, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h4000_0000);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA);
		send_pair(32'd12, 32'd18);
		send_pair(32'd7, 32'd13);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF);
		send_pair(32'd65536, 32'd98304);
		drain();

		// Random phases: light sender gaps, heavy gaps, then back to back
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 14 : (phase == 1) ? 66 : 0;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				send_random();
			end
			drain();
		end

		// Let any stray strobe show up before the verdict
		repeat (TAIL_CYC) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/egcd_pkg.sv
rtl/egcd_alu.sv
rtl/euclid_gcd_unit.sv
dv/gcd_checker.sv
dv/tb_top.sv
